@@ rtl/u8u16_pkg.sv @@
// u8u16_pkg: types, codes and constants shared by the utf-8 to utf-16 decoder
// no dependencies; imported by every module of the decoder
package u8u16_pkg;

  // report status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // queue between the classifier and the emitter
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // code point limits and surrogate bases
  localparam logic [31:0] Replacement  = 32'h0000_FFFD;
  localparam logic [31:0] MaxCodepoint = 32'h0010_FFFF;
  localparam logic [20:0] HalfBase     = 21'h01_0000;
  localparam logic [15:0] HighSurr     = 16'hD800;
  localparam logic [15:0] LowSurr      = 16'hDC00;

  // offset removed from the accumulator, by sequence length
  localparam logic [31:0] LenOffset [8] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
    32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080, 32'h0000_0000
  };

  // one classified beat handed from front to back
  typedef struct packed {
    logic        has_char;
    logic [31:0] acc;
    logic [2:0]  seq;
    logic        has_report;
    status_t     status;
    logic [15:0] consumed;
  } dec_item_t;

  // sequence length from a lead byte, zero for a stray continuation byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'h80:8'hBF]: len = 3'd0;
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      default:       len = 3'd6;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/u8u16_front.sv @@
// u8u16_front: takes source bytes, tracks sequences, offsets and errors
// uses u8u16_pkg; pushes classified items into u8u16_queue
module u8u16_front
  import u8u16_pkg::*;
#(
  parameter logic [15:0] COUNT_CAP = 16'hFFFF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  input  logic       queue_full,
  output logic       push,
  output dec_item_t  item
);

  logic [31:0] value_accum, value_accum_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [2:0]  seq_length, seq_length_next;
  status_t     error_status, error_status_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [15:0] char_start_offset, char_start_offset_next;
  logic        accept;
  logic [2:0]  len;
  status_t     rep_status;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign len      = lead_length(in_byte);

  // per-beat decode and report build
  always_comb begin
    value_accum_next       = value_accum;
    bytes_left_next        = bytes_left;
    seq_length_next        = seq_length;
    error_status_next      = error_status;
    byte_offset_next       = byte_offset;
    char_start_offset_next = char_start_offset;
    item                   = '0;
    rep_status             = ST_OK;
    if (accept) begin
      if (error_status == ST_OK) begin
        if (bytes_left == 3'd0) begin
          char_start_offset_next = byte_offset;
          if (len == 3'd0) begin
            error_status_next = ST_CORRUPT;
          end else begin
            seq_length_next  = len;
            bytes_left_next  = len - 3'd1;
            value_accum_next = {24'd0, in_byte};
          end
        end else begin
          value_accum_next = {value_accum[25:0], 6'd0} + {24'd0, in_byte};
          bytes_left_next  = bytes_left - 3'd1;
        end
        if (error_status_next == ST_OK) begin
          if (byte_offset < COUNT_CAP) begin
            byte_offset_next = byte_offset + 16'd1;
          end
          if (bytes_left_next == 3'd0) begin
            item.has_char    = 1'b1;
            item.acc         = value_accum_next;
            item.seq         = seq_length_next;
            value_accum_next = '0;
            seq_length_next  = '0;
          end
        end
      end
      if (last_byte) begin
        rep_status = error_status_next;
        if (rep_status == ST_OK && bytes_left_next != 3'd0) begin
          rep_status = ST_TRUNC;
        end
        item.has_report = 1'b1;
        item.status     = rep_status;
        item.consumed   = (rep_status == ST_OK) ? byte_offset_next : char_start_offset_next;
        value_accum_next       = '0;
        bytes_left_next        = '0;
        seq_length_next        = '0;
        error_status_next      = ST_OK;
        byte_offset_next       = '0;
        char_start_offset_next = '0;
      end
    end
  end

  assign push = item.has_char || item.has_report;

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      value_accum       <= '0;
      bytes_left        <= '0;
      seq_length        <= '0;
      error_status      <= ST_OK;
      byte_offset       <= '0;
      char_start_offset <= '0;
    end else begin
      value_accum       <= value_accum_next;
      bytes_left        <= bytes_left_next;
      seq_length        <= seq_length_next;
      error_status      <= error_status_next;
      byte_offset       <= byte_offset_next;
      char_start_offset <= char_start_offset_next;
    end
  end

  // an open sequence never coexists with an error
  a_open_seq_no_error: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 3'd0 |-> error_status == ST_OK)
    else $error("sequence open while in error");

  // an open sequence always has its length recorded
  a_open_seq_has_len: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 3'd0 |-> seq_length > bytes_left)
    else $error("bytes left exceeds sequence length");

endmodule

@@ rtl/u8u16_queue.sv @@
// u8u16_queue: short queue of classified items between front and back
// uses u8u16_pkg for the item type and depth
module u8u16_queue
  import u8u16_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dec_item_t push_item,
  output logic      full,
  output logic      head_valid,
  output dec_item_t head_item,
  input  logic      pop
);

  dec_item_t        entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full       = (count == QCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCntW'(push) - QCntW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QueueDepth))
    else $error("queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

@@ rtl/u8u16_back.sv @@
// u8u16_back: turns queued items into code units and string reports
// uses u8u16_pkg; reads u8u16_queue, drives the output register
module u8u16_back
  import u8u16_pkg::*;
#(
  parameter logic [15:0] COUNT_CAP = 16'hFFFF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        swap_bytes,
  input  logic        head_valid,
  input  dec_item_t   head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] unit_word,
  output logic        end_report,
  output logic [1:0]  status,
  output logic [15:0] consumed_bytes,
  output logic [15:0] units_written
);

  // job register: pending pieces of one item
  logic        job_first, job_lo, job_rep;
  logic        job_first_next, job_lo_next, job_rep_next;
  logic [20:0] job_cp;
  status_t     job_status;
  logic [15:0] job_consumed;
  logic [15:0] unit_count;

  logic        slot_free, take, take_unit, load;
  logic        job_pair;
  logic [20:0] cp_off;
  logic [15:0] unit_val;
  logic [31:0] head_val;
  logic [20:0] head_cp;

  // code point of the queue head
  always_comb begin
    head_val = head_item.acc - LenOffset[head_item.seq];
    if (head_val > MaxCodepoint) begin
      head_cp = Replacement[20:0];
    end else begin
      head_cp = head_val[20:0];
    end
  end

  // pick the next piece of the job
  always_comb begin
    job_pair  = (job_cp[20:16] != 5'd0);
    cp_off    = job_cp - HalfBase;
    slot_free = !out_valid || out_ready;
    take      = slot_free && (job_first || job_lo || job_rep);
    take_unit = take && (job_first || job_lo);
    if (job_first) begin
      unit_val = job_pair ? (HighSurr | {6'd0, cp_off[19:10]}) : job_cp[15:0];
    end else begin
      unit_val = LowSurr | {6'd0, job_cp[9:0]};
    end
    job_first_next = job_first;
    job_lo_next    = job_lo;
    job_rep_next   = job_rep;
    if (take) begin
      if (job_first) begin
        job_first_next = 1'b0;
      end else if (job_lo) begin
        job_lo_next = 1'b0;
      end else begin
        job_rep_next = 1'b0;
      end
    end
    load = head_valid && !(job_first_next || job_lo_next || job_rep_next);
    pop  = load;
  end

  // job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_first <= 1'b0;
      job_lo    <= 1'b0;
      job_rep   <= 1'b0;
    end else if (load) begin
      job_first <= head_item.has_char;
      job_lo    <= head_item.has_char && (head_cp[20:16] != 5'd0);
      job_rep   <= head_item.has_report;
    end else begin
      job_first <= job_first_next;
      job_lo    <= job_lo_next;
      job_rep   <= job_rep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_cp       <= head_cp;
      job_status   <= head_item.status;
      job_consumed <= head_item.consumed;
    end
  end

  // units written in the current string
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_count <= '0;
    end else if (take_unit) begin
      if (unit_count < COUNT_CAP) begin
        unit_count <= unit_count + 16'd1;
      end
    end else if (take) begin
      unit_count <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (take_unit) begin
        unit_word      <= swap_bytes ? {unit_val[7:0], unit_val[15:8]} : unit_val;
        end_report     <= 1'b0;
        status         <= ST_OK;
        consumed_bytes <= '0;
        units_written  <= '0;
      end else begin
        unit_word      <= '0;
        end_report     <= 1'b1;
        status         <= job_status;
        consumed_bytes <= job_consumed;
        units_written  <= unit_count;
      end
    end
  end

  // a report closes the string's unit count
  a_report_clears_count: assert property (@(posedge clk) disable iff (rst)
    take && !take_unit |=> unit_count == '0)
    else $error("unit count not cleared after report");

endmodule

@@ rtl/utf8_to_utf16_decoder.sv @@
// utf8_to_utf16_decoder: top level of the utf-8 to utf-16 stream decoder
// uses u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back
//
//  channel  handshake             payload
//  in       in_valid / in_ready   in_byte, last_byte
//  out      out_valid / out_ready unit_word, end_report, status,
//                                 consumed_bytes, units_written
//  cfg      cfg_write             cfg_data (swap_bytes)
//
// one source byte is taken per cycle while the item queue has room
// each byte gives zero to three result beats, one per cycle from the emitter while out is ready
// a result passes through the item queue, the job register and the output register
// the four-entry item queue lets the front keep taking bytes while out stalls
// synchronous reset clears all string state and swap_bytes
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] unit_word,
  output logic        end_report,
  output logic [1:0]  status,
  output logic [15:0] consumed_bytes,
  output logic [15:0] units_written
);

  localparam logic [15:0] CountCap =
    (MAX_STRING_BYTES > 32'd65535) ? 16'hFFFF : MAX_STRING_BYTES[15:0];

  logic      swap_bytes;
  logic      push, full, head_valid, pop;
  dec_item_t push_item, head_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_bytes <= 1'b0;
    end else if (cfg_write) begin
      swap_bytes <= cfg_data;
    end
  end

  u8u16_front #(
    .COUNT_CAP (CountCap)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .queue_full (full),
    .push       (push),
    .item       (push_item)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  u8u16_back #(
    .COUNT_CAP (CountCap)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .swap_bytes     (swap_bytes),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .unit_word      (unit_word),
    .end_report     (end_report),
    .status         (status),
    .consumed_bytes (consumed_bytes),
    .units_written  (units_written)
  );

endmodule
